FILE: design/tg7_pkg.sv
package tg7_pkg;

   localparam int CHANNELS = 7;
   localparam int OCTAVES = 3;

   localparam int OP_W = 2;
   localparam int NOTE_W = 3;
   localparam int OCTAVE_W = 2;
   localparam int LEVELS_W = 7;
   localparam int PERIOD_W = 16;

   // channels that show up in the level field
   localparam int LEVEL_CHANNELS = (CHANNELS < LEVELS_W) ? CHANNELS : LEVELS_W;

   localparam logic [NOTE_W-1:0] NOTE_NONE = NOTE_W'(7);

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 2'd0,
      OP_SET_ONE = 2'd1,
      OP_SET_ALL = 2'd2
   } op_type;

   localparam int ROM_ROWS = 3;
   localparam int ROM_COLS = 7;

   // floor(floor(8000000 / f) / 2), one row per octave
   localparam logic [PERIOD_W-1:0] PERIOD_ROM [ROM_ROWS][ROM_COLS] = '{
      '{16'd30581, 16'd27247, 16'd24271, 16'd22909, 16'd20408, 16'd18181, 16'd16200},
      '{16'd15290, 16'd13619, 16'd12135, 16'd11454, 16'd10204, 16'd9090,  16'd8098},
      '{16'd7645,  16'd6810,  16'd6067,  16'd5727,  16'd5102,  16'd4545,  16'd4049}
   };

   typedef struct packed {
      logic                tick;
      logic                set;
      logic                enable;
      logic [PERIOD_W-1:0] load_value;
      logic [PERIOD_W-1:0] count_next;
   } chan_ctl_type;

   // out-of-table octaves and channels load zero
   function automatic logic [PERIOD_W-1:0] rom_lookup(input logic [OCTAVE_W-1:0] row,
                                                      input int col);
      logic [PERIOD_W-1:0] value;
      value = '0;
      if (int'(row) < ROM_ROWS && col >= 0 && col < ROM_COLS) begin
         value = PERIOD_ROM[row][col[2:0]];
      end
      return value;
   endfunction

endpackage

FILE: design/tg7_channel.sv
module tg7_channel (
   input  logic                            clock,
   input  logic                            reset,
   input  tg7_pkg::chan_ctl_type           ctl,
   output logic                            level_in,
   output logic [tg7_pkg::PERIOD_W-1:0]    half_period_in
);
   import tg7_pkg::*;

   logic [PERIOD_W-1:0] compare_ff, compare_in;
   logic [PERIOD_W-1:0] half_period_ff;
   logic                enabled_ff, enabled_in;
   logic                level_ff;

   always_comb begin
      compare_in     = compare_ff;
      half_period_in = half_period_ff;
      enabled_in     = enabled_ff;
      level_in       = level_ff;
      if (ctl.tick) begin
         if (compare_ff == ctl.count_next) begin
            compare_in = compare_ff + half_period_ff;
            if (enabled_ff) begin
               level_in = ~level_ff;
            end
         end
      end else if (ctl.set) begin
         if (ctl.enable) begin
            enabled_in     = 1'b1;
            half_period_in = ctl.load_value;
         end else begin
            // drop the tone and force the line low
            enabled_in = 1'b0;
            level_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_ff     <= '0;
         half_period_ff <= '0;
         enabled_ff     <= 1'b0;
         level_ff       <= 1'b0;
      end else begin
         compare_ff     <= compare_in;
         half_period_ff <= half_period_in;
         enabled_ff     <= enabled_in;
         level_ff       <= level_in;
      end
   end

endmodule

FILE: design/seven_channel_tone_generator_top.sv
// Seven-channel square-wave tone generator.
//
// Input channel (req_): one transaction per command. op 0 is a tick that
// advances the shared 16-bit counter; channels whose compare value matches
// advance it by their half-period and, when enabled, toggle their level.
// op 1 sets the channel named by req_note (note 7 is ignored), op 2 sets all
// channels. Octaves 0..2 enable the tone with a half-period from the note
// table; octave 3 disables the channel and drives its level low.
// Result channel (rsp_): exactly one transaction per command, carrying all
// levels and the half-period of req_note after the command took effect.
// A command is taken by the input register, and its channel update is
// loaded into the result register once the result register can advance.
// One command is accepted every cycle while the receiver does not stall;
// the channel update is combinational.
// Reset clears the counter, all compare values, half-periods, enables and
// levels, and empties both registers. When the receiver stalls, the result
// register holds and the input register still takes one more command; then
// req_ready drops until rsp_ready returns.
module seven_channel_tone_generator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tg7_pkg::OP_W-1:0]          req_op,
   input  logic [tg7_pkg::NOTE_W-1:0]        req_note,
   input  logic [tg7_pkg::OCTAVE_W-1:0]      req_octave,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tg7_pkg::LEVELS_W-1:0]      rsp_tone_levels,
   output logic [tg7_pkg::PERIOD_W-1:0]      rsp_half_period
);
   import tg7_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [OP_W-1:0]     op_ff;
   logic [NOTE_W-1:0]   note_ff;
   logic [OCTAVE_W-1:0] octave_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEVELS_W-1:0] levels_ff, levels_in;
   logic [PERIOD_W-1:0] half_period_ff, half_period_in;

   logic [PERIOD_W-1:0] tick_ff, tick_in;

   logic advance;
   logic fire;
   logic do_tick;
   logic enable;

   chan_ctl_type        ctl [CHANNELS];
   logic                chan_level [CHANNELS];
   logic [PERIOD_W-1:0] chan_period [CHANNELS];

   assign advance     = !rsp_valid_ff || rsp_ready;
   assign fire        = in_valid_ff && advance;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   assign do_tick = fire && (op_ff == OP_TICK);
   assign enable  = int'(octave_ff) < OCTAVES;
   assign tick_in = do_tick ? tick_ff + PERIOD_W'(1) : tick_ff;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      always_comb begin
         ctl[i].tick       = do_tick;
         ctl[i].set        = fire && ((op_ff == OP_SET_ALL) ||
                             ((op_ff == OP_SET_ONE) && (note_ff != NOTE_NONE) &&
                              (int'(note_ff) == i)));
         ctl[i].enable     = enable;
         ctl[i].load_value = rom_lookup(octave_ff, i);
         ctl[i].count_next = tick_ff + PERIOD_W'(1);
      end

      tg7_channel u_channel (
         .clock          (clock),
         .reset          (reset),
         .ctl            (ctl[i]),
         .level_in       (chan_level[i]),
         .half_period_in (chan_period[i])
      );
   end

   always_comb begin
      levels_in      = '0;
      half_period_in = '0;
      for (int i = 0; i < LEVEL_CHANNELS; i++) begin
         levels_in[i] = chan_level[i];
      end
      for (int i = 0; i < CHANNELS; i++) begin
         if ((note_ff != NOTE_NONE) && (int'(note_ff) == i)) begin
            half_period_in = chan_period[i];
         end
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         op_ff     <= req_op;
         note_ff   <= req_note;
         octave_ff <= req_octave;
      end
      if (fire) begin
         levels_ff      <= levels_in;
         half_period_ff <= half_period_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tone_levels = levels_ff;
   assign rsp_half_period = half_period_ff;

endmodule

FILE: design/tg7_checker.sv
module tg7_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [tg7_pkg::OP_W-1:0]          req_op,
   input logic [tg7_pkg::NOTE_W-1:0]        req_note,
   input logic [tg7_pkg::OCTAVE_W-1:0]      req_octave,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tg7_pkg::LEVELS_W-1:0]      rsp_tone_levels,
   input logic [tg7_pkg::PERIOD_W-1:0]      rsp_half_period
);
   import tg7_pkg::*;

   // both registers come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("registers not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tone_levels) &&
                                  $stable(rsp_half_period))
      else $error("stalled response changed");

   // a global disable silences every channel
   a_all_off: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_SET_ALL) && (req_octave == 2'd3)
      ##1 rsp_ready |=> rsp_valid && (rsp_tone_levels == '0))
      else $error("levels not cleared by global disable");

   a_note_none: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_note == NOTE_NONE)
      ##1 rsp_ready |=> rsp_valid && (rsp_half_period == '0))
      else $error("nonzero half-period reported for unused note");

endmodule

bind seven_channel_tone_generator_top tg7_checker u_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tg7_pkg::*;

   localparam logic [OP_W-1:0]     OP_UNUSED  = 2'd3;
   localparam logic [OCTAVE_W-1:0] OCTAVE_OFF = 2'd3;

   localparam int TABLE_ROWS     = 3;
   localparam int TABLE_COLS     = 7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 60;
   localparam int HOLD_AT_RESULT = 40;
   localparam int RUN_TICKS      = 400;
   localparam int RANDOM_ITEMS   = 720;
   localparam int DRAIN_CYCLES   = 10;

   // half-period in ticks per octave and note
   localparam logic [PERIOD_W-1:0] HALF_PERIOD_TABLE [TABLE_ROWS][TABLE_COLS] = '{
      '{16'd30581, 16'd27247, 16'd24271, 16'd22909, 16'd20408, 16'd18181, 16'd16200},
      '{16'd15290, 16'd13619, 16'd12135, 16'd11454, 16'd10204, 16'd9090,  16'd8098},
      '{16'd7645,  16'd6810,  16'd6067,  16'd5727,  16'd5102,  16'd4545,  16'd4049}
   };

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [NOTE_W-1:0]   note;
      logic [OCTAVE_W-1:0] octave;
      logic [2:0]          gap;
   } tone_cmd_type;

   typedef struct packed {
      logic [LEVELS_W-1:0] levels;
      logic [PERIOD_W-1:0] half_period;
   } tone_status_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_op = '0;
   logic [NOTE_W-1:0]   req_note = '0;
   logic [OCTAVE_W-1:0] req_octave = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [LEVELS_W-1:0] rsp_tone_levels;
   logic [PERIOD_W-1:0] rsp_half_period;

   seven_channel_tone_generator_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_note        (req_note),
      .req_octave      (req_octave),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tone_levels (rsp_tone_levels),
      .rsp_half_period (rsp_half_period)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // tone generator state as the commands leave it
   logic [PERIOD_W-1:0] tick_counter;
   logic [PERIOD_W-1:0] compare_at [CHANNELS];
   logic [PERIOD_W-1:0] half_period_of [CHANNELS];
   logic                tone_enabled [CHANNELS];
   logic                tone_level [CHANNELS];

   tone_cmd_type    pending_cmds [$];
   tone_status_type expected_status [$];
   tone_cmd_type    offered_cmd;
   tone_status_type wanted;
   int unsigned     idle_count;
   int unsigned     stall_left;
   int unsigned     results_seen;
   int unsigned     quiet_cycles;
   int unsigned     error_count = 0;
   int unsigned     ticks_queued = 0;

   function automatic void program_channel(input int ch, input logic [OCTAVE_W-1:0] octave);
      if (int'(octave) < OCTAVES) begin
         tone_enabled[ch] = 1'b1;
         if (int'(octave) < TABLE_ROWS && ch < TABLE_COLS)
            half_period_of[ch] = HALF_PERIOD_TABLE[octave][ch];
         else
            half_period_of[ch] = '0;
      end else begin
         tone_enabled[ch] = 1'b0;
         tone_level[ch] = 1'b0;
      end
   endfunction

   function automatic tone_status_type apply_tone_cmd(input tone_cmd_type cmd);
      tone_status_type status;
      status = '0;
      case (cmd.op)
         OP_TICK: begin
            tick_counter = tick_counter + 1'b1;
            for (int i = 0; i < CHANNELS; i++) begin
               if (compare_at[i] == tick_counter) begin
                  compare_at[i] = compare_at[i] + half_period_of[i];
                  if (tone_enabled[i])
                     tone_level[i] = ~tone_level[i];
               end
            end
         end
         OP_SET_ONE: begin
            if (cmd.note != NOTE_NONE && int'(cmd.note) < CHANNELS)
               program_channel(int'(cmd.note), cmd.octave);
         end
         OP_SET_ALL: begin
            for (int i = 0; i < CHANNELS; i++)
               program_channel(i, cmd.octave);
         end
         default: ;
      endcase
      for (int i = 0; i < CHANNELS && i < LEVELS_W; i++)
         status.levels[i] = tone_level[i];
      if (cmd.note != NOTE_NONE && int'(cmd.note) < CHANNELS)
         status.half_period = half_period_of[cmd.note];
      return status;
   endfunction

   task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [NOTE_W-1:0] note,
                            input logic [OCTAVE_W-1:0] octave, input bit no_gap);
      tone_cmd_type cmd;
      cmd.op = op;
      cmd.note = note;
      cmd.octave = octave;
      cmd.gap = no_gap ? 3'd0 : 3'($urandom_range(0, 4));
      if (op == OP_TICK)
         ticks_queued++;
      pending_cmds.push_back(cmd);
   endtask

   // driver: offer queued transactions, predict each one on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_count = 0;
         tick_counter = '0;
         for (int i = 0; i < CHANNELS; i++) begin
            compare_at[i] = '0;
            half_period_of[i] = '0;
            tone_enabled[i] = 1'b0;
            tone_level[i] = 1'b0;
         end
      end else begin
         if (req_valid && req_ready)
            expected_status.push_back(apply_tone_cmd(offered_cmd));
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() == 0) begin
               req_valid <= 1'b0;
            end else if (idle_count < pending_cmds[0].gap) begin
               idle_count++;
               req_valid <= 1'b0;
            end else begin
               offered_cmd = pending_cmds.pop_front();
               idle_count = 0;
               req_valid <= 1'b1;
               req_op <= offered_cmd.op;
               req_note <= offered_cmd.note;
               req_octave <= offered_cmd.octave;
            end
         end
      end
   end

   // monitor: check each result transaction against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         results_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected transaction levels=%h half_period=%0d", $time,
                        rsp_tone_levels, rsp_half_period);
               error_count++;
            end else begin
               wanted = expected_status.pop_front();
               if (rsp_tone_levels !== wanted.levels) begin
                  $display("%0t: tone_levels expected %h actual %h", $time,
                           wanted.levels, rsp_tone_levels);
                  error_count++;
               end
               if (rsp_half_period !== wanted.half_period) begin
                  $display("%0t: half_period expected %0d actual %0d", $time,
                           wanted.half_period, rsp_half_period);
                  error_count++;
               end
            end
            // hold off once long enough for the block to back up its input
            if (results_seen == HOLD_AT_RESULT)
               stall_left = LONG_HOLD;
            else if ((results_seen / 300) % 2 == 0)
               stall_left = 0;
            else
               stall_left = $urandom_range(0, 4);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      int unsigned n;
      int unsigned pick;
      logic [OP_W-1:0] op;
      logic [OCTAVE_W-1:0] octave;

      // directed: reset state, table corners, ignored note, disables, unused op
      queue_cmd(OP_TICK,    3'd0, 2'd0, 1'b0);
      queue_cmd(OP_UNUSED,  3'd7, 2'd3, 1'b0);
      queue_cmd(OP_SET_ONE, 3'd0, 2'd0, 1'b0);
      queue_cmd(OP_SET_ONE, 3'd6, 2'd2, 1'b0);
      queue_cmd(OP_SET_ONE, 3'd7, 2'd1, 1'b0);
      queue_cmd(OP_SET_ONE, 3'd3, OCTAVE_OFF, 1'b0);
      queue_cmd(OP_SET_ALL, 3'd7, 2'd2, 1'b0);
      queue_cmd(OP_SET_ALL, 3'd5, 2'd1, 1'b0);
      queue_cmd(OP_SET_ALL, 3'd0, OCTAVE_OFF, 1'b0);
      queue_cmd(OP_SET_ALL, 3'd4, 2'd0, 1'b0);
      queue_cmd(OP_UNUSED,  3'd6, 2'd0, 1'b0);
      queue_cmd(OP_TICK,    3'd7, 2'd3, 1'b0);
      queue_cmd(OP_TICK,    3'd1, 2'd2, 1'b0);
      queue_cmd(OP_SET_ONE, 3'd2, 2'd1, 1'b0);
      queue_cmd(OP_SET_ONE, 3'd5, 2'd2, 1'b0);
      queue_cmd(OP_SET_ONE, 3'd1, 2'd0, 1'b0);
      queue_cmd(OP_SET_ONE, 3'd4, 2'd2, 1'b0);
      queue_cmd(OP_SET_ONE, 3'd6, OCTAVE_OFF, 1'b0);
      queue_cmd(OP_SET_ONE, 3'd6, 2'd2, 1'b0);
      queue_cmd(OP_SET_ALL, 3'd3, 2'd2, 1'b0);
      queue_cmd(OP_SET_ONE, 3'd0, 2'd1, 1'b0);
      queue_cmd(OP_TICK,    3'd6, 2'd1, 1'b0);

      // a long run of ticks back to back, with sparse reprogramming mixed in
      n = 0;
      while (ticks_queued < RUN_TICKS) begin
         if ($urandom_range(0, 63) == 0) begin
            op = OP_SET_ONE;
            pick = $urandom_range(0, 7);
            if (pick >= 5)
               op = OP_SET_ALL;
            else if (pick == 4)
               op = OP_UNUSED;
            octave = ($urandom_range(0, 7) == 0) ? OCTAVE_OFF : 2'($urandom_range(0, 2));
         end else begin
            op = OP_TICK;
            octave = 2'($urandom_range(0, 3));
         end
         queue_cmd(op, 3'($urandom_range(0, 7)), octave, ((n / 400) % 2) == 0);
         n++;
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 19);
         if (pick < 10)
            op = OP_TICK;
         else if (pick < 15)
            op = OP_SET_ONE;
         else if (pick < 18)
            op = OP_SET_ALL;
         else
            op = OP_UNUSED;
         queue_cmd(op, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                   ((i / 200) % 2) == 1);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_status.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: sim.f
design/tg7_pkg.sv
design/tg7_channel.sv
design/seven_channel_tone_generator_top.sv
design/tg7_checker.sv
tb/tb_top.sv
